[src/pwpt_pkg.sv]
// Shared types and constants of the pulse-width packet transmitter.
package pwpt_pkg;

	localparam int TICK_W = 10;
	localparam int CNT_W  = 5;
	localparam int PKT_W  = 16;
	localparam int IDX_W  = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_SHORT_HIGH    = 3'd0,
		REG_LONG_HIGH     = 3'd1,
		REG_PREAMBLE_HIGH = 3'd2,
		REG_LOW_AFTER_ONE = 3'd3,
		REG_LOW_AFTER_ZERO = 3'd4,
		REG_PACKET_BITS   = 3'd5,
		REG_PREAMBLE_BITS = 3'd6
	} cfg_reg_t;

	localparam logic [TICK_W-1:0] RST_SHORT_HIGH     = 10'd17;
	localparam logic [TICK_W-1:0] RST_LONG_HIGH      = 10'd37;
	localparam logic [TICK_W-1:0] RST_PREAMBLE_HIGH  = 10'd53;
	localparam logic [TICK_W-1:0] RST_LOW_AFTER_ONE  = 10'd16;
	localparam logic [TICK_W-1:0] RST_LOW_AFTER_ZERO = 10'd36;
	localparam logic [CNT_W-1:0]  RST_PACKET_BITS    = 5'd13;
	localparam logic [CNT_W-1:0]  RST_PREAMBLE_BITS  = 5'd6;

	typedef struct packed {
		logic [TICK_W-1:0] short_high_ticks;
		logic [TICK_W-1:0] long_high_ticks;
		logic [TICK_W-1:0] preamble_high_ticks;
		logic [TICK_W-1:0] low_after_one_ticks;
		logic [TICK_W-1:0] low_after_zero_ticks;
		logic [CNT_W-1:0]  packet_bits;
		logic [CNT_W-1:0]  preamble_bits;
	} cfg_t;

	typedef struct packed {
		logic done_res;
		logic tx_enable;
		logic ask_level;
	} res_t;

endpackage

[src/pwpt_cfg.sv]
// Configuration register file of the pulse-width packet transmitter.
module pwpt_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [pwpt_pkg::IDX_W-1:0] wr_index,
	input  logic [pwpt_pkg::TICK_W-1:0] wr_data,
	output pwpt_pkg::cfg_t             cfg
);

	pwpt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_high_ticks     <= pwpt_pkg::RST_SHORT_HIGH;
			cfg_q.long_high_ticks      <= pwpt_pkg::RST_LONG_HIGH;
			cfg_q.preamble_high_ticks  <= pwpt_pkg::RST_PREAMBLE_HIGH;
			cfg_q.low_after_one_ticks  <= pwpt_pkg::RST_LOW_AFTER_ONE;
			cfg_q.low_after_zero_ticks <= pwpt_pkg::RST_LOW_AFTER_ZERO;
			cfg_q.packet_bits          <= pwpt_pkg::RST_PACKET_BITS;
			cfg_q.preamble_bits        <= pwpt_pkg::RST_PREAMBLE_BITS;
		end else if (wr_en) begin
			unique case (pwpt_pkg::cfg_reg_t'(wr_index))
				pwpt_pkg::REG_SHORT_HIGH:     cfg_q.short_high_ticks     <= wr_data;
				pwpt_pkg::REG_LONG_HIGH:      cfg_q.long_high_ticks      <= wr_data;
				pwpt_pkg::REG_PREAMBLE_HIGH:  cfg_q.preamble_high_ticks  <= wr_data;
				pwpt_pkg::REG_LOW_AFTER_ONE:  cfg_q.low_after_one_ticks  <= wr_data;
				pwpt_pkg::REG_LOW_AFTER_ZERO: cfg_q.low_after_zero_ticks <= wr_data;
				pwpt_pkg::REG_PACKET_BITS: begin
					cfg_q.packet_bits <= wr_data[pwpt_pkg::CNT_W-1:0];
				end
				pwpt_pkg::REG_PREAMBLE_BITS: begin
					cfg_q.preamble_bits <= wr_data[pwpt_pkg::CNT_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/pwpt_step.sv]
// Transmitter state and per-word step logic: pulse countdown and phase sequencing.
module pwpt_step #(
	parameter int WORD_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_en,
	input  logic                       in_start,
	input  logic [pwpt_pkg::PKT_W-1:0] in_packet,
	input  pwpt_pkg::cfg_t             cfg,
	output pwpt_pkg::res_t             res
);

	localparam int POS_W = $clog2(WORD_BITS);
	localparam logic [POS_W-1:0] TOP_POS = POS_W'(WORD_BITS - 1);
	localparam logic [pwpt_pkg::CNT_W:0] WORD_LIM = (pwpt_pkg::CNT_W + 1)'(WORD_BITS);

	logic [WORD_BITS-1:0]          word_q;
	logic [pwpt_pkg::CNT_W-1:0]    bit_idx_q;
	logic [pwpt_pkg::TICK_W-1:0]   tick_q;
	logic                          low_pend_q;
	logic                          active_q;
	logic                          key_q;

	logic [pwpt_pkg::CNT_W-1:0]    bit_idx_d;
	logic [pwpt_pkg::TICK_W-1:0]   tick_d;
	logic                          low_pend_d;
	logic                          active_d;
	logic                          key_d;
	logic                          done_d;

	logic [pwpt_pkg::CNT_W-1:0]    prev_idx;
	logic                          bit_cur;
	logic                          bit_prev;
	logic                          in_preamble;

	// Bit idx counted from the top of the word; zero outside the word.
	function automatic logic word_bit(input logic [WORD_BITS-1:0] w,
			input logic [pwpt_pkg::CNT_W-1:0] idx);
		logic [POS_W-1:0] pos;
		logic             b;
		pos = TOP_POS - idx[POS_W-1:0];
		b = 1'b0;
		if ({1'b0, idx} < WORD_LIM) begin
			b = w[pos];
		end
		return b;
	endfunction

	assign prev_idx    = bit_idx_q - pwpt_pkg::CNT_W'(1);
	assign bit_cur     = word_bit(word_q, bit_idx_q);
	assign bit_prev    = (bit_idx_q != '0) && word_bit(word_q, prev_idx);
	assign in_preamble = bit_idx_q < cfg.preamble_bits;

	always_comb begin
		bit_idx_d  = bit_idx_q;
		tick_d     = tick_q;
		low_pend_d = low_pend_q;
		active_d   = active_q;
		key_d      = key_q;
		done_d     = 1'b0;
		if (active_q) begin
			if (tick_q != '0) begin
				tick_d = tick_q - pwpt_pkg::TICK_W'(1);
			end else if (low_pend_q) begin
				low_pend_d = 1'b0;
				key_d      = 1'b0;
				if (in_preamble) begin
					tick_d = cfg.short_high_ticks;
				end else if (bit_prev) begin
					tick_d = cfg.low_after_one_ticks;
				end else begin
					tick_d = cfg.low_after_zero_ticks;
				end
			end else if (bit_idx_q >= cfg.packet_bits) begin
				active_d = 1'b0;
				key_d    = 1'b0;
				done_d   = 1'b1;
			end else begin
				key_d = 1'b1;
				if (!bit_cur) begin
					tick_d = cfg.short_high_ticks;
				end else if (in_preamble) begin
					tick_d = cfg.preamble_high_ticks;
				end else begin
					tick_d = cfg.long_high_ticks;
				end
				low_pend_d = 1'b1;
				bit_idx_d  = bit_idx_q + pwpt_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q     <= '0;
			bit_idx_q  <= '0;
			tick_q     <= '0;
			low_pend_q <= 1'b0;
			active_q   <= 1'b0;
			key_q      <= 1'b0;
		end else if (in_en) begin
			if (in_start) begin
				// reload; pulse counter and low flag carry over
				word_q    <= WORD_BITS'(in_packet);
				bit_idx_q <= '0;
				key_q     <= 1'b0;
				active_q  <= 1'b1;
			end else begin
				bit_idx_q  <= bit_idx_d;
				tick_q     <= tick_d;
				low_pend_q <= low_pend_d;
				active_q   <= active_d;
				key_q      <= key_d;
			end
		end
	end

	always_comb begin
		if (in_start) begin
			res.ask_level = 1'b0;
			res.tx_enable = 1'b1;
			res.done_res  = 1'b0;
		end else begin
			res.ask_level = key_d;
			res.tx_enable = active_d;
			res.done_res  = done_d;
		end
	end

endmodule

[src/pulse_width_packet_transmitter.sv]
// Pulse-width packet transmitter top level: stream ports, config port, result register.
// A word's result appears on the master side in the cycle after it is accepted.
// Throughput: one word per cycle unless a held result stalls; the register refills
// as it drains. A tick on an active packet makes one decrement or one phase step.
// Reset (arst_n low, asynchronous): transmitter idle, key low, registers at defaults.
module pulse_width_packet_transmitter #(
	parameter int WORD_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [pwpt_pkg::PKT_W-1:0]  s_tdata,   // [15:0] packet
	input  logic                        s_tuser,   // [0] kind: 1 = start, 0 = tick
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,   // [0] ask_level, [1] tx_enable, [7:2] zero
	output logic                        m_tlast,   // done_res
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pwpt_pkg::IDX_W-1:0]  cfg_index,
	input  logic [pwpt_pkg::TICK_W-1:0] cfg_data
);

	pwpt_pkg::cfg_t cfg;
	pwpt_pkg::res_t res;
	pwpt_pkg::res_t res_q;
	logic           out_valid_q;
	logic           in_acc;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign in_acc    = s_tvalid && s_tready;

	pwpt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	pwpt_step #(
		.WORD_BITS (WORD_BITS)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_en     (in_acc),
		.in_start  (s_tuser),
		.in_packet (s_tdata),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, res_q.tx_enable, res_q.ask_level};
	assign m_tlast  = res_q.done_res;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tdata[0] && !m_tdata[1])
		else $error("end-of-packet word with transmitter still on");

	a_key_needs_en: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[1])
		else $error("key high while transmitter disabled");

	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> m_tvalid && m_tdata[1] && !m_tdata[0] && !m_tlast)
		else $error("start word did not yield enabled, key-low result");

endmodule

[tb/sv/pwpt_stream_checker.sv]
// Stream checker for the pulse-width packet transmitter: predicts each result and compares it.
`timescale 1ns / 1ps
module pwpt_stream_checker
	import pwpt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [PKT_W-1:0]  s_tdata,   // [15:0] packet
	input  logic              s_tuser,   // [0] kind: 1 = start, 0 = tick
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [7:0]        m_tdata,   // [0] ask_level, [1] tx_enable, [7:2] zero
	input  logic              m_tlast,   // done_res
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [TICK_W-1:0] cfg_data,
	output int                mismatches,
	output int                outstanding,
	output int                results_seen,
	output int                packets_ended,
	output int                reg_writes,
	output logic              tx_busy
);

	localparam int WORD_BITS = 16;

	cfg_t              regs;
	logic [PKT_W-1:0]  shift_word;
	logic [CNT_W-1:0]  bit_pos;
	logic [TICK_W-1:0] ticks_left;
	logic              low_due;
	logic              key_on;
	res_t              expected_q[$];

	// Bit pos counted from the top of the word; zero past the end.
	function automatic logic word_bit(input logic [CNT_W-1:0] pos);
		if (pos >= WORD_BITS)
			return 1'b0;
		return shift_word[WORD_BITS - 1 - pos];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		logic ended;
		if (!arst_n) begin
			regs.short_high_ticks     = RST_SHORT_HIGH;
			regs.long_high_ticks      = RST_LONG_HIGH;
			regs.preamble_high_ticks  = RST_PREAMBLE_HIGH;
			regs.low_after_one_ticks  = RST_LOW_AFTER_ONE;
			regs.low_after_zero_ticks = RST_LOW_AFTER_ZERO;
			regs.packet_bits          = RST_PACKET_BITS;
			regs.preamble_bits        = RST_PREAMBLE_BITS;
			shift_word    = '0;
			bit_pos       = '0;
			ticks_left    = '0;
			low_due       = 1'b0;
			tx_busy       = 1'b0;
			key_on        = 1'b0;
			expected_q.delete();
			mismatches    = 0;
			outstanding   = 0;
			results_seen  = 0;
			packets_ended = 0;
			reg_writes    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_SHORT_HIGH:     regs.short_high_ticks     = cfg_data;
					REG_LONG_HIGH:      regs.long_high_ticks      = cfg_data;
					REG_PREAMBLE_HIGH:  regs.preamble_high_ticks  = cfg_data;
					REG_LOW_AFTER_ONE:  regs.low_after_one_ticks  = cfg_data;
					REG_LOW_AFTER_ZERO: regs.low_after_zero_ticks = cfg_data;
					REG_PACKET_BITS:    regs.packet_bits          = cfg_data[CNT_W-1:0];
					REG_PREAMBLE_BITS:  regs.preamble_bits        = cfg_data[CNT_W-1:0];
					default: ;
				endcase
				reg_writes++;
			end

			if (m_tvalid && m_tready) begin
				got.ask_level = m_tdata[0];
				got.tx_enable = m_tdata[1];
				got.done_res  = m_tlast;
				results_seen++;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected word ask %0b en %0b done %0b", $realtime,
							got.ask_level, got.tx_enable, got.done_res);
				end else begin
					want = expected_q.pop_front();
					if (got !== want || m_tdata[7:2] !== 6'd0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected ask %0b en %0b done %0b, got ask %0b en %0b done %0b pad %h",
								$realtime, want.ask_level, want.tx_enable, want.done_res,
								got.ask_level, got.tx_enable, got.done_res, m_tdata[7:2]);
					end
				end
			end

			if (s_tvalid && s_tready) begin
				ended = 1'b0;
				if (s_tuser) begin
					// restart keeps the pulse counter and the pending low phase
					shift_word = s_tdata;
					bit_pos    = '0;
					key_on     = 1'b0;
					tx_busy    = 1'b1;
				end else if (tx_busy) begin
					if (ticks_left != 0) begin
						ticks_left = ticks_left - 1'b1;
					end else if (low_due) begin
						low_due = 1'b0;
						key_on  = 1'b0;
						if (bit_pos < regs.preamble_bits)
							ticks_left = regs.short_high_ticks;
						else if (bit_pos != 0 && word_bit(bit_pos - 1'b1))
							ticks_left = regs.low_after_one_ticks;
						else
							ticks_left = regs.low_after_zero_ticks;
					end else if (bit_pos >= regs.packet_bits) begin
						tx_busy = 1'b0;
						key_on  = 1'b0;
						ended   = 1'b1;
						packets_ended++;
					end else begin
						key_on = 1'b1;
						if (!word_bit(bit_pos))
							ticks_left = regs.short_high_ticks;
						else if (bit_pos < regs.preamble_bits)
							ticks_left = regs.preamble_high_ticks;
						else
							ticks_left = regs.long_high_ticks;
						low_due = 1'b1;
						bit_pos = bit_pos + 1'b1;
					end
				end
				want.ask_level = key_on;
				want.tx_enable = tx_busy;
				want.done_res  = ended;
				expected_q.push_back(want);
			end
			outstanding = expected_q.size();
		end
	end

endmodule

[tb/sv/tb_pulse_width_packet_transmitter.sv]
// Testbench top for the pulse-width packet transmitter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_pulse_width_packet_transmitter;
	import pwpt_pkg::*;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [PKT_W-1:0]  s_tdata;
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [7:0]        m_tdata;
	logic              m_tlast;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index;
	logic [TICK_W-1:0] cfg_data;

	int   mismatches;
	int   outstanding;
	int   results_seen;
	int   packets_ended;
	int   reg_writes;
	logic tx_busy;

	int   items_sent;
	int   burst_left;
	bit   no_gaps;
	logic hold_go;

	pulse_width_packet_transmitter #(
		.WORD_BITS(16)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	pwpt_stream_checker stream_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.packets_ended(packets_ended),
		.reg_writes   (reg_writes),
		.tx_busy      (tx_busy)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	// Output side: random stall patterns, plus one long hold-off on request.
	initial begin
		int       hold_left;
		int       mode_left;
		int       beat;
		bit       hold_fired;
		rx_mode_t mode;
		hold_left  = 0;
		mode_left  = 0;
		beat       = 0;
		hold_fired = 1'b0;
		mode       = RX_OPEN;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_fired) begin
				hold_fired = 1'b1;
				hold_left  = 250;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 160);
				end
				mode_left--;
				beat++;
				case (mode)
					RX_OPEN:   m_tready <= 1'b1;
					RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= ((beat % 6) < 3);
				endcase
			end
		end
	end

	// Offer one word; bursts of back-to-back words are separated by random gaps.
	task automatic send_word(input logic kind, input logic [PKT_W-1:0] pkt);
		int gap;
		if (burst_left == 0) begin
			gap = no_gaps ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= pkt;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	// Drop valid and wait until every predicted word has come back.
	task automatic drain_results();
		s_tvalid  <= 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [TICK_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_config(input logic [TICK_W-1:0] short_hi, input logic [TICK_W-1:0] long_hi,
		input logic [TICK_W-1:0] pre_hi, input logic [TICK_W-1:0] low_one,
		input logic [TICK_W-1:0] low_zero, input logic [TICK_W-1:0] pkt_bits,
		input logic [TICK_W-1:0] pre_bits);
		write_reg(REG_SHORT_HIGH, short_hi);
		write_reg(REG_LONG_HIGH, long_hi);
		write_reg(REG_PREAMBLE_HIGH, pre_hi);
		write_reg(REG_LOW_AFTER_ONE, low_one);
		write_reg(REG_LOW_AFTER_ZERO, low_zero);
		write_reg(REG_PACKET_BITS, pkt_bits);
		write_reg(REG_PREAMBLE_BITS, pre_bits);
		cfg_valid <= 1'b0;
	endtask

	// Start a packet and tick it to the end; some packets get restarted partway.
	task automatic run_packet(input logic [PKT_W-1:0] pkt, input int cap);
		int ticks;
		int restart_at;
		restart_at = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 30) : -1;
		send_word(1'b1, pkt);
		ticks = 0;
		while (tx_busy && ticks < cap) begin
			if (ticks == restart_at)
				send_word(1'b1, 16'($urandom));
			else
				send_word(1'b0, 16'($urandom));
			ticks++;
		end
	endtask

	function automatic logic [TICK_W-1:0] rand_ticks();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return TICK_W'($urandom_range(0, 3));
		if (r < 95)
			return TICK_W'($urandom_range(4, 12));
		return TICK_W'($urandom_range(13, 30));
	endfunction

	// Upper half of the write data is noise; only the low five bits land.
	function automatic logic [TICK_W-1:0] rand_count();
		int r;
		int val;
		r = $urandom_range(0, 99);
		if (r < 8)
			val = $urandom_range(17, 31);
		else if (r < 12)
			val = 0;
		else
			val = $urandom_range(1, 16);
		return {5'($urandom_range(0, 31)), 5'(val)};
	endfunction

	initial begin
		int phase;
		int rand_start;
		int npk;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tuser    = 1'b0;
		s_tdata    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_SHORT_HIGH;
		cfg_data   = '0;
		hold_go    = 1'b0;
		no_gaps    = 1'b0;
		items_sent = 0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: idle tick, start, restart while the high pulse runs
		send_word(1'b0, 16'hFFFF);
		send_word(1'b1, 16'hFFFF);
		repeat (5) send_word(1'b0, 16'h0000);
		send_word(1'b1, 16'h0000);
		repeat (2) send_word(1'b0, 16'hFFFF);

		// zero bit count: the restarted packet takes its low phase at bit zero, then stops
		drain_results();
		load_config(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
		while (tx_busy) send_word(1'b0, 16'($urandom));
		send_word(1'b1, 16'h1234);
		send_word(1'b0, 16'h0000);
		send_word(1'b0, 16'hFFFF);

		// distinct pulse lengths, all five used; the low after a one comes twice
		drain_results();
		load_config(10'd20, 10'd35, 10'd50, 10'd45, 10'd60, 10'd3, 10'd1);
		run_packet(16'hA000, 2000);

		// zero-length pulses, whole word, write data with upper bits set
		drain_results();
		load_config(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'h3F0, 10'h3FF);
		run_packet(16'hFFFF, 2000);
		run_packet(16'h0000, 2000);
		run_packet(16'h8001, 2000);
		drain_results();
		load_config(10'd1, 10'd2, 10'd0, 10'd1, 10'd2, 10'h01F, 10'h010);
		run_packet(16'($urandom), 2000);

		phase      = 0;
		rand_start = items_sent;
		while (items_sent - rand_start < 550) begin
			drain_results();
			load_config(rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks(),
				rand_count(), rand_count());
			if (phase == 0) begin
				// keep offering while the output side holds off
				no_gaps = 1'b1;
				hold_go <= 1'b1;
			end
			npk = $urandom_range(3, 8);
			repeat (npk) begin
				if (items_sent - rand_start < 550) begin
					if ($urandom_range(0, 9) == 0)
						repeat ($urandom_range(1, 3)) send_word(1'b0, 16'($urandom));
					run_packet(16'($urandom), 2000);
				end
			end
			no_gaps = 1'b0;
			phase++;
		end

		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		$display("covered %0d input words, %0d results, %0d finished packets, %0d register writes",
			items_sent, results_seen, packets_ended, reg_writes);
		$display("pulses of zero to 60 ticks, counts up to 31 bits, restarts and a long output stall");
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
